// ----- rtl/bfw_pkg.sv -----
// bfw_pkg: shared types, codes and weight tables for the bilateral filter window block.
// No dependencies; used by bfw_ctrl, bfw_dp, bilateral_filter_window and the testbench.

package bfw_pkg;

    localparam logic [63:0] COEF_A = 64'd4284243288;
    localparam logic [63:0] COEF_B = 64'd4286385946;
    localparam int STAB_LEN = 128;
    localparam int GTAB_LEN = 256;

    // configuration register indexes (word address)
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MODE   = 2'd2;

    typedef logic [15:0] stab_t [STAB_LEN];
    typedef logic [15:0] gtab_t [GTAB_LEN];

    typedef struct packed {
        logic [11:0] w;
        logic [12:0] h;
        logic [24:0] n;
        logic [14:0] d;
    } bfw_geom_t;

    typedef struct packed {
        logic accept;
        logic center_rd;
        logic center_cap;
        logic tap_issue;
        logic div_start;
        logic div_step;
        logic load_out;
        logic finish;
    } bfw_cmd_t;

    typedef struct packed {
        logic need_filter;
        logic tap_last;
        logic pipe_busy;
        logic div_last;
        logic out_free;
    } bfw_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CENTER,
        ST_GRAB,
        ST_TAPS,
        ST_DRAIN,
        ST_DIV,
        ST_OUT
    } bfw_state_t;

    // Q32.32 multiply, round to nearest
    function automatic logic [63:0] qmul32(logic [63:0] x, logic [63:0] y);
        logic [127:0] t;
        t = {64'd0, x} * {64'd0, y} + 128'h8000_0000;
        return t[95:32];
    endfunction

    function automatic logic [15:0] to_q16(logic [63:0] v);
        logic [63:0] r;
        r = (v + 64'h8000) >> 16;
        return (r > 64'd65535) ? 16'hFFFF : r[15:0];
    endfunction

    function automatic stab_t build_s();
        stab_t tab;
        logic [63:0] v;
        v = 64'h1_0000_0000;
        for (int k = 0; k < STAB_LEN; k++)
        begin
            tab[k] = to_q16(v);
            v = qmul32(v, COEF_A);
        end
        return tab;
    endfunction

    function automatic gtab_t build_g();
        gtab_t tab;
        logic [63:0] v;
        logic [63:0] f;
        logic [63:0] b2;
        v  = 64'h1_0000_0000;
        f  = COEF_B;
        b2 = qmul32(COEF_B, COEF_B);
        for (int k = 0; k < GTAB_LEN; k++)
        begin
            tab[k] = to_q16(v);
            v = qmul32(v, f);
            f = qmul32(f, b2);
        end
        return tab;
    endfunction

endpackage

// ----- rtl/bfw_ram.sv -----
// bfw_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.

module bfw_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 22528
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/bfw_ctrl.sv -----
// bfw_ctrl: sequencer for the bilateral filter window (accept, center read, tap sweep,
// divide, output). Depends on bfw_pkg.

module bfw_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  bfw_pkg::bfw_status_t  status,
    output logic                  in_ready,
    output bfw_pkg::bfw_cmd_t     cmd
);

    import bfw_pkg::*;

    bfw_state_t state_reg;
    bfw_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && status.need_filter)
                begin
                    state_next = ST_CENTER;
                end
            end
            ST_CENTER: state_next = ST_GRAB;
            ST_GRAB:   state_next = ST_TAPS;
            ST_TAPS:
            begin
                if (status.tap_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_CENTER: cmd.center_rd  = 1'b1;
            ST_GRAB:   cmd.center_cap = 1'b1;
            ST_TAPS:   cmd.tap_issue  = 1'b1;
            ST_DRAIN:  cmd.div_start  = !status.pipe_busy;
            ST_DIV:    cmd.div_step   = 1'b1;
            ST_OUT:
            begin
                cmd.load_out = status.out_free;
                cmd.finish   = status.out_free;
            end
            default: cmd = '0;
        endcase
    end

endmodule

// ----- rtl/bfw_dp.sv -----
// bfw_dp: line store, raster counters, tap weight pipeline, accumulators, divider
// and output register. Depends on bfw_pkg and bfw_ram.

module bfw_dp #(
    parameter int MAX_WIDTH = 2048,
    parameter int WINDOW    = 11
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bfw_pkg::bfw_cmd_t     cmd,
    output bfw_pkg::bfw_status_t  status,
    input  bfw_pkg::bfw_geom_t    geom,
    input  logic                  color,
    input  logic                  cfg_restart,
    input  logic [23:0]           s_tdata,
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,
    output logic                  m_tlast
);

    import bfw_pkg::*;

    localparam int HALF  = WINDOW / 2;
    localparam int SPAN  = 2 * HALF + 1;
    localparam int RING  = SPAN * MAX_WIDTH;
    localparam int AW    = $clog2(RING);
    localparam int TW    = $clog2(SPAN);
    localparam int TB    = $clog2(SPAN * SPAN);
    localparam int NUM_W = 24 + TB;
    localparam int DEN_W = 16 + TB;
    localparam int DSH_W = DEN_W + 7;
    localparam logic [AW:0]   RING_C = (AW + 1)'(RING);
    localparam logic [TW-1:0] HALF_T = TW'(HALF);
    localparam logic [TW-1:0] LAST_T = TW'(SPAN - 1);
    localparam stab_t S_TAB = build_s();
    localparam gtab_t G_TAB = build_g();

    function automatic logic [AW-1:0] ring_sub(logic [AW-1:0] a, logic [AW:0] b);
        logic [AW:0] t;
        t = {1'b0, a} - b;
        if ({1'b0, a} < b)
        begin
            t = t + RING_C;
        end
        return t[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] ring_add(logic [AW-1:0] a, logic [AW:0] b);
        logic [AW:0] t;
        t = {1'b0, a} + b;
        if (t >= RING_C)
        begin
            t = t - RING_C;
        end
        return t[AW-1:0];
    endfunction

    function automatic logic [6:0] dist2(logic [TW-1:0] tx, logic [TW-1:0] ty);
        logic [TW-1:0] ox;
        logic [TW-1:0] oy;
        logic [7:0]    sx;
        logic [7:0]    sy;
        ox = (tx >= HALF_T) ? tx - HALF_T : HALF_T - tx;
        oy = (ty >= HALF_T) ? ty - HALF_T : HALF_T - ty;
        sx = 8'(ox) * 8'(ox);
        sy = 8'(oy) * 8'(oy);
        return 7'(sx + sy);
    endfunction

    // raster position and ring pointers
    logic [25:0]   p_reg;
    logic [AW-1:0] wptr_reg;
    logic [AW-1:0] qa_reg;
    logic [AW-1:0] tap_addr_reg;
    logic [AW-1:0] row_base_reg;
    logic          last_reg;
    logic [11:0]   out_col_reg;
    logic [12:0]   out_row_reg;
    logic [TW-1:0] tx_reg;
    logic [TW-1:0] ty_reg;
    logic [23:0]   center_reg;

    // tap pipeline
    logic             v1_reg, v2_reg, v3_reg;
    logic             in1_reg, in2_reg, in3_reg;
    logic [6:0]       d2_1_reg;
    logic [15:0]      s2_reg;
    logic [15:0]      g2_reg   [3];
    logic [7:0]       px2_reg  [3];
    logic [15:0]      wt3_reg  [3];
    logic [7:0]       px3_reg  [3];
    logic [NUM_W-1:0] num_reg  [3];
    logic [DEN_W-1:0] den_reg  [3];
    logic [NUM_W-1:0] rem_reg  [3];
    logic [DSH_W-1:0] dsh_reg  [3];
    logic [7:0]       quo_reg  [3];
    logic [2:0]       div_cnt_reg;

    logic        m_valid_reg;
    logic [23:0] m_data_reg;
    logic        m_last_reg;

    logic [23:0]   ram_rdata;
    logic [AW-1:0] ram_raddr;
    logic          ram_we;
    logic [23:0]   px_in;
    logic [AW:0]   d_ext;
    logic [AW:0]   w_ext;
    logic          p_lt_n, ge_d, q_lt_n, q_last, need_filter, restart_pos;
    logic [25:0]   q_pos;
    logic [AW-1:0] wptr_inc;
    logic [13:0]   rsum;
    logic [12:0]   csum;
    logic          tap_in;

    assign d_ext  = (AW + 1)'(geom.d);
    assign w_ext  = (AW + 1)'(geom.w);
    assign p_lt_n = p_reg < {1'b0, geom.n};
    assign ge_d   = p_reg >= 26'(geom.d);
    assign q_pos  = p_reg - 26'(geom.d);
    assign q_lt_n = q_pos < {1'b0, geom.n};
    assign q_last = q_pos == {1'b0, geom.n - 25'd1};
    assign need_filter = ge_d && q_lt_n;
    assign restart_pos = (ge_d && !q_lt_n) || (need_filter && q_last);
    assign wptr_inc = (wptr_reg == AW'(RING - 1)) ? '0 : wptr_reg + 1'b1;

    // a flush tick stores a zero pixel; gray mode keeps only the blue byte
    assign px_in  = s_tuser ? 24'd0 : (color ? s_tdata : {16'd0, s_tdata[7:0]});
    assign ram_we = cmd.accept && p_lt_n;
    assign ram_raddr = cmd.center_rd ? qa_reg : tap_addr_reg;

    bfw_ram #(
        .WIDTH (24),
        .DEPTH (RING)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wptr_reg),
        .wdata (px_in),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // tap inside the image
    assign rsum   = {1'b0, out_row_reg} + 14'(ty_reg);
    assign csum   = {1'b0, out_col_reg} + 13'(tx_reg);
    assign tap_in = (rsum >= 14'(HALF)) && (rsum < {1'b0, geom.h} + 14'(HALF)) &&
                    (csum >= 13'(HALF)) && (csum < {1'b0, geom.w} + 13'(HALF));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg       <= '0;
            wptr_reg    <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.tap_issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (cmd.load_out)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_restart)
            begin
                p_reg       <= '0;
                wptr_reg    <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end
            else
            begin
                if (cmd.accept)
                begin
                    if (restart_pos)
                    begin
                        p_reg    <= '0;
                        wptr_reg <= '0;
                    end
                    else
                    begin
                        p_reg    <= p_reg + 26'd1;
                        wptr_reg <= wptr_inc;
                    end
                end
                if (cmd.finish)
                begin
                    if (last_reg)
                    begin
                        out_col_reg <= '0;
                        out_row_reg <= '0;
                    end
                    else if (out_col_reg == geom.w - 12'd1)
                    begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + 13'd1;
                    end
                    else
                    begin
                        out_col_reg <= out_col_reg + 12'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            qa_reg   <= ring_sub(wptr_reg, d_ext);
            last_reg <= q_last;
        end
        if (cmd.center_rd)
        begin
            tap_addr_reg <= ring_sub(qa_reg, d_ext);
            row_base_reg <= ring_sub(qa_reg, d_ext);
        end
        if (cmd.center_cap)
        begin
            center_reg <= ram_rdata;
            tx_reg     <= '0;
            ty_reg     <= '0;
        end
        if (cmd.tap_issue)
        begin
            if (tx_reg == LAST_T)
            begin
                tx_reg       <= '0;
                ty_reg       <= ty_reg + 1'b1;
                tap_addr_reg <= ring_add(row_base_reg, w_ext);
                row_base_reg <= ring_add(row_base_reg, w_ext);
            end
            else
            begin
                tx_reg       <= tx_reg + 1'b1;
                tap_addr_reg <= ring_add(tap_addr_reg, (AW + 1)'(1));
            end
        end
        in1_reg  <= tap_in;
        d2_1_reg <= dist2(tx_reg, ty_reg);
        s2_reg   <= S_TAB[d2_1_reg];
        in2_reg  <= in1_reg;
        in3_reg  <= in2_reg;
        if (cmd.div_start)
        begin
            div_cnt_reg <= 3'd7;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg - 3'd1;
        end
        if (cmd.load_out)
        begin
            m_data_reg <= {color ? quo_reg[2] : 8'd0, color ? quo_reg[1] : 8'd0, quo_reg[0]};
            m_last_reg <= last_reg;
        end
    end

    // one lane per color channel
    for (genvar c = 0; c < 3; c++)
    begin : g_lane
        logic [7:0]  px1;
        logic [7:0]  ctr;
        logic [7:0]  dg;
        logic [31:0] prod;
        logic [23:0] wpx;

        assign px1  = ram_rdata[8*c +: 8];
        assign ctr  = center_reg[8*c +: 8];
        assign dg   = (px1 > ctr) ? px1 - ctr : ctr - px1;
        assign prod = 32'(s2_reg) * 32'(g2_reg[c]);
        assign wpx  = 24'(wt3_reg[c]) * 24'(px3_reg[c]);

        always_ff @(posedge clk)
        begin
            g2_reg[c]  <= G_TAB[dg];
            px2_reg[c] <= px1;
            wt3_reg[c] <= prod[31:16];
            px3_reg[c] <= px2_reg[c];
            if (cmd.center_cap)
            begin
                num_reg[c] <= '0;
                den_reg[c] <= '0;
            end
            else if (v3_reg && in3_reg)
            begin
                num_reg[c] <= num_reg[c] + NUM_W'(wpx);
                den_reg[c] <= den_reg[c] + DEN_W'(wt3_reg[c]);
            end
            // restoring divide, one quotient bit per step; average never exceeds 255
            if (cmd.div_start)
            begin
                rem_reg[c] <= num_reg[c];
                dsh_reg[c] <= {den_reg[c], 7'd0};
                quo_reg[c] <= '0;
            end
            else if (cmd.div_step)
            begin
                if (rem_reg[c] >= NUM_W'(dsh_reg[c]))
                begin
                    rem_reg[c] <= rem_reg[c] - NUM_W'(dsh_reg[c]);
                    quo_reg[c] <= {quo_reg[c][6:0], 1'b1};
                end
                else
                begin
                    quo_reg[c] <= {quo_reg[c][6:0], 1'b0};
                end
                dsh_reg[c] <= dsh_reg[c] >> 1;
            end
        end
    end

    assign status.need_filter = need_filter;
    assign status.tap_last    = (tx_reg == LAST_T) && (ty_reg == LAST_T);
    assign status.pipe_busy   = v1_reg || v2_reg || v3_reg;
    assign status.div_last    = div_cnt_reg == 3'd0;
    assign status.out_free    = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ----- rtl/bilateral_filter_window.sv -----
// An item that completes a window gives its result after a center read and capture, a sweep
//   of every tap, a pipeline drain, a divide and an output load, in that order.
// Throughput: one item per cycle while no result is due (first HALF rows plus HALF pixels of
//   a frame, and ticks past its end); otherwise no new item is taken until the result is
//   loaded, as the single line store read port walks every tap; a held output delays it further.
// Reset: asynchronous, active low; clears position counters, sequencer and output valid.
//   Line store contents are undefined after reset (no clearing pass).
// Depends on bfw_pkg, bfw_ctrl, bfw_dp, bfw_ram.

module bilateral_filter_window #(
    parameter int MAX_WIDTH = 2048,
    parameter int WINDOW    = 11
) (
    input  logic        clk,
    input  logic        rst_n,
    // slave stream: one pixel or flush tick per transaction
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] in_blue, [15:8] in_green, [23:16] in_red
    input  logic        s_tuser,   // [0] command (1 = flush tick)
    // master stream: one filtered pixel per transaction
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_blue, [15:8] out_green, [23:16] out_red
    output logic        m_tlast,   // last pixel of the frame
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import bfw_pkg::*;

    localparam int MAXW_CAP = (MAX_WIDTH > 4095) ? 4095 : MAX_WIDTH;
    localparam logic [14:0] HALF_C = 15'(WINDOW / 2);

    logic [11:0] width_reg;
    logic [12:0] height_reg;
    logic        mode_reg;

    logic        cfg_wr;
    logic        cfg_restart;
    logic [1:0]  cfg_idx;
    bfw_geom_t   geom;
    bfw_cmd_t    cmd;
    bfw_status_t status;
    logic [11:0] w_eff;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // any write to a defined register restarts the frame at position 0
    always_comb
    begin
        case (cfg_idx)
            REG_WIDTH, REG_HEIGHT, REG_MODE: cfg_restart = cfg_wr;
            default:                          cfg_restart = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 12'd640;
            height_reg <= 13'd480;
            mode_reg   <= 1'b1;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_WIDTH:  width_reg  <= pwdata[11:0];
                REG_HEIGHT: height_reg <= pwdata[12:0];
                REG_MODE:   mode_reg   <= pwdata[0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_WIDTH:  prdata = {20'd0, width_reg};
            REG_HEIGHT: prdata = {19'd0, height_reg};
            REG_MODE:   prdata = {31'd0, mode_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // effective geometry: zero means one, width capped at the line store size
    always_comb
    begin
        w_eff = width_reg;
        if (width_reg > 12'(MAXW_CAP))
        begin
            w_eff = 12'(MAXW_CAP);
        end
        if (width_reg == 12'd0)
        begin
            w_eff = 12'd1;
        end
        geom.w = w_eff;
        geom.h = (height_reg == 13'd0) ? 13'd1 : height_reg;
        geom.n = 25'(w_eff) * 25'(geom.h);
        geom.d = 15'({3'd0, w_eff} * HALF_C) + HALF_C;
    end

    bfw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .status   (status),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    bfw_dp #(
        .MAX_WIDTH (MAX_WIDTH),
        .WINDOW    (WINDOW)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .geom        (geom),
        .color       (mode_reg),
        .cfg_restart (cfg_restart),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

// ----- rtl/bfw_checker.sv -----
// bfw_checker: port-level assertions for bilateral_filter_window, attached by bind.
// Depends on bilateral_filter_window.

module bfw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast,
    input logic        pready
);

    // output register is cleared by reset
    ast_reset_clears: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("m_tvalid set during reset");

    // a result only rises after a filter pass, never straight after an input transaction
    ast_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!(s_tvalid && s_tready)))
        else $error("result appeared right after input transaction");

    // input side is blocked during the pass that loads a result
    ast_busy_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("input ready while a result was being computed");

    ast_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output transaction changed");

    ast_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind bilateral_filter_window bfw_checker u_bfw_checker (.*);

// ----- sim/bilateral_filter_window_tb.sv -----
// Self-checking testbench for bilateral_filter_window (11x11 bilateral filter on a pixel stream).
// Holds its own weight tables and filter predictor; needs the RTL and bfw_pkg only.
`timescale 1ns / 100ps

module bilateral_filter_window_tb;
    import bfw_pkg::*;

    localparam int HALF_WIN  = 5;
    localparam int MAXW      = 2048;
    localparam int RING_SIZE = 11 * MAXW;
    localparam int DIST_LEN  = 2 * HALF_WIN * HALF_WIN + 1;
    localparam int DRAIN_CYC = 200;   // idle wait, longer than one window's filter pass
    localparam bit CMD_PIXEL = 1'b0;
    localparam bit CMD_FLUSH = 1'b1;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;      // [7:0] in_blue, [15:8] in_green, [23:16] in_red
    logic        s_tuser = 1'b0;    // [0] command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;           // [7:0] out_blue, [15:8] out_green, [23:16] out_red
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    bilateral_filter_window dut (.*);

    always #1 clk = ~clk;

    // filtered pixels still owed by the block: {last, red, green, blue}
    logic [24:0] pending_pixels[$];
    int          err_count = 0;
    int          pixels_out = 0;

    // shadow of the block: registers, raster position, line ring
    logic [11:0] cfg_width = 12'd640;
    logic [12:0] cfg_height = 13'd480;
    logic        cfg_color = 1'b1;
    int unsigned col_pos = 0;
    int unsigned row_pos = 0;
    logic [23:0] line_ring[RING_SIZE];
    logic [15:0] dist_wt[DIST_LEN];
    logic [15:0] diff_wt[256];

    function automatic logic [63:0] q32_mul(logic [63:0] x, logic [63:0] y);
        logic [127:0] t;
        t = {64'd0, x} * {64'd0, y} + 128'h8000_0000;
        return t[95:32];
    endfunction

    function automatic logic [15:0] q16_sat(logic [63:0] v);
        logic [63:0] r;
        r = (v + 64'h8000) >> 16;
        return (r > 64'd65535) ? 16'hFFFF : r[15:0];
    endfunction

    // weight tables: A^k over squared distance, B^(g*g) over intensity step
    task automatic make_weights();
        logic [63:0] v;
        logic [63:0] f;
        logic [63:0] b2;
        v = 64'h1_0000_0000;
        for (int k = 0; k < DIST_LEN; k++)
        begin
            dist_wt[k] = q16_sat(v);
            v = q32_mul(v, 64'd4284243288);
        end
        v  = 64'h1_0000_0000;
        f  = 64'd4286385946;
        b2 = q32_mul(f, f);
        for (int k = 0; k < 256; k++)
        begin
            diff_wt[k] = q16_sat(v);
            v = q32_mul(v, f);
            f = q32_mul(f, b2);
        end
    endtask

    function automatic int unsigned eff_w();
        if (cfg_width == 0) return 1;
        if (cfg_width > MAXW) return MAXW;
        return cfg_width;
    endfunction

    function automatic int unsigned eff_h();
        return (cfg_height == 0) ? 1 : cfg_height;
    endfunction

    function automatic logic [7:0] smooth_channel(int unsigned q, int unsigned w,
                                                  int unsigned h, int sh);
        int r;
        int c;
        int rr;
        int cc;
        logic [7:0] ctr;
        logic [7:0] px;
        logic [7:0] dg;
        longint unsigned num;
        longint unsigned den;
        longint unsigned wt;
        r   = q / w;
        c   = q % w;
        ctr = line_ring[q % RING_SIZE][sh +: 8];
        num = 0;
        den = 0;
        for (int dy = -HALF_WIN; dy <= HALF_WIN; dy++)
            for (int dx = -HALF_WIN; dx <= HALF_WIN; dx++)
            begin
                rr = r + dy;
                cc = c + dx;
                if (rr < 0 || rr >= int'(h) || cc < 0 || cc >= int'(w))
                    continue;
                px  = line_ring[(rr * w + cc) % RING_SIZE][sh +: 8];
                dg  = (px > ctr) ? px - ctr : ctr - px;
                wt  = (longint'(dist_wt[dy * dy + dx * dx]) * diff_wt[dg]) >> 16;
                num += wt * px;
                den += wt;
            end
        if (den == 0)
            return 8'd0;
        num = num / den;
        return (num > 255) ? 8'd255 : num[7:0];
    endfunction

    // advance the raster position by one transaction; returns 1 if a pixel leaves
    function automatic bit filter_step(logic cmd, logic [23:0] d, output logic [24:0] res);
        int unsigned w;
        int unsigned h;
        int unsigned n;
        int unsigned lag;
        int unsigned p;
        int unsigned q;
        w   = eff_w();
        h   = eff_h();
        n   = w * h;
        lag = HALF_WIN * w + HALF_WIN;
        p   = row_pos * w + col_pos;
        res = '0;
        if (p < n)
            line_ring[p % RING_SIZE] = (cmd == CMD_FLUSH) ? 24'd0 :
                                       cfg_color ? d : {16'd0, d[7:0]};
        col_pos++;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (p < lag)
            return 1'b0;
        q = p - lag;
        if (q >= n)
        begin
            col_pos = 0;
            row_pos = 0;
            return 1'b0;
        end
        res[7:0] = smooth_channel(q, w, h, 0);
        if (cfg_color)
        begin
            res[15:8]  = smooth_channel(q, w, h, 8);
            res[23:16] = smooth_channel(q, w, h, 16);
        end
        res[24] = (q == n - 1);
        if (q == n - 1)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        return 1'b1;
    endfunction

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_WIDTH:  cfg_width  = val[11:0];
            REG_HEIGHT: cfg_height = val[12:0];
            default:    cfg_color  = val[0];
        endcase
        col_pos = 0;
        row_pos = 0;
    endtask

    // sender pause: wait out every owed pixel, then cover the no-result latency
    task automatic drain_idle();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic set_geometry(logic [11:0] w, logic [12:0] h, logic mode);
        drain_idle();
        apb_write(REG_WIDTH, {20'd0, w});
        apb_write(REG_HEIGHT, {19'd0, h});
        apb_write(REG_MODE, {31'd0, mode});
    endtask

    // one input transaction; typed_exp overrides the predicted pixel when set
    task automatic send_pixel(logic cmd, logic [23:0] d, int gap,
                              bit typed_exp = 1'b0, logic [24:0] typed_val = '0);
        logic [24:0] res;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= d;
        do @(posedge clk); while (!s_tready);
        if (filter_step(cmd, d, res))
            pending_pixels.push_back(typed_exp ? typed_val : res);
    endtask

    function automatic int draw_gap();
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    endfunction

    // result side: random stalls, plus one long hold so the input backs up
    initial
    begin : sink
        int gap;
        logic [24:0] want;
        @(posedge rst_n);
        forever
        begin
            gap = (pixels_out == 40) ? 600 : draw_gap();
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            pixels_out++;
            if (pending_pixels.size() == 0)
            begin
                $error("unexpected output transaction data=%h last=%b", m_tdata, m_tlast);
                err_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (m_tdata[7:0] !== want[7:0])
                begin
                    $error("out_blue expected %0d got %0d", want[7:0], m_tdata[7:0]);
                    err_count++;
                end
                if (m_tdata[15:8] !== want[15:8])
                begin
                    $error("out_green expected %0d got %0d", want[15:8], m_tdata[15:8]);
                    err_count++;
                end
                if (m_tdata[23:16] !== want[23:16])
                begin
                    $error("out_red expected %0d got %0d", want[23:16], m_tdata[23:16]);
                    err_count++;
                end
                if (m_tlast !== want[24])
                begin
                    $error("out_last expected %0b got %0b", want[24], m_tlast);
                    err_count++;
                end
            end
        end
    end

    // directed rows: two 1x1 frames, color then gray, trailing flushes / ignored pixels
    typedef struct {
        logic        cmd;
        logic [23:0] data;
        bit          typed;
        logic [24:0] res;
    } stim_row_t;

    stim_row_t directed[22] = '{
        '{CMD_PIXEL, 24'h8000FF, 0, '0},
        '{CMD_FLUSH, 24'h000000, 0, '0}, '{CMD_FLUSH, 24'hFFFFFF, 0, '0},
        '{CMD_FLUSH, 24'h000000, 0, '0}, '{CMD_FLUSH, 24'h000000, 0, '0},
        '{CMD_FLUSH, 24'h000000, 0, '0}, '{CMD_FLUSH, 24'h000000, 0, '0},
        '{CMD_FLUSH, 24'h000000, 0, '0}, '{CMD_FLUSH, 24'h000000, 0, '0},
        '{CMD_FLUSH, 24'h000000, 0, '0},
        '{CMD_PIXEL, 24'h123456, 1, {1'b1, 24'h8000FF}},   // past frame end: data ignored
        '{CMD_PIXEL, 24'hFFFF5A, 0, '0},
        '{CMD_PIXEL, 24'hFFFFFF, 0, '0}, '{CMD_FLUSH, 24'h000000, 0, '0},
        '{CMD_PIXEL, 24'h000000, 0, '0}, '{CMD_FLUSH, 24'h000000, 0, '0},
        '{CMD_PIXEL, 24'hFFFFFF, 0, '0}, '{CMD_FLUSH, 24'h000000, 0, '0},
        '{CMD_FLUSH, 24'h000000, 0, '0}, '{CMD_FLUSH, 24'h000000, 0, '0},
        '{CMD_FLUSH, 24'h000000, 0, '0},
        '{CMD_FLUSH, 24'h000000, 1, {1'b1, 24'h00005A}}    // gray: green/red forced to zero
    };

    initial
    begin : stimulus
        int sent;
        int frame_len;
        int big_len;
        logic [11:0] w;
        logic [12:0] h;
        make_weights();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        set_geometry(12'd1, 13'd1, 1'b1);
        for (int i = 0; i < 22; i++)
        begin
            if (i == 11)
                set_geometry(12'd1, 13'd1, 1'b0);
            send_pixel(directed[i].cmd, directed[i].data, draw_gap(),
                       directed[i].typed, directed[i].res);
        end

        // random frames; one phase at the width/height extremes
        sent = 0;
        for (int ph = 0; sent < 1600; ph++)
        begin
            if (ph == 3)
            begin
                // width saturates to MAXW: no window completes this early, no result due
                set_geometry(12'hFFF, 13'h1FFF, 1'b1);
                big_len = 200;
                for (int i = 0; i < big_len; i++)
                begin
                    send_pixel(($urandom_range(0, 19) == 0) ? CMD_FLUSH : CMD_PIXEL,
                               24'($urandom), draw_gap());
                    sent++;
                end
                continue;
            end
            w = ($urandom_range(0, 19) == 0) ? 12'd0 : 12'($urandom_range(1, 12));
            h = ($urandom_range(0, 19) == 0) ? 13'd0 : 13'($urandom_range(1, 9));
            set_geometry(w, h, 1'($urandom_range(0, 1)));
            frame_len = eff_w() * eff_h() + HALF_WIN * eff_w() + HALF_WIN;
            if ($urandom_range(0, 4) == 0)
                frame_len = $urandom_range(1, frame_len);   // broken frame, restarted
            for (int i = 0; i < frame_len; i++)
            begin
                send_pixel(($urandom_range(0, 19) == 0) ? CMD_FLUSH : CMD_PIXEL,
                           24'($urandom), draw_gap());
                sent++;
            end
        end
        s_tvalid <= 1'b0;

        while (pending_pixels.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ----- bilateral_filter_window.f -----
rtl/bfw_pkg.sv
rtl/bfw_ram.sv
rtl/bfw_ctrl.sv
rtl/bfw_dp.sv
rtl/bilateral_filter_window.sv
rtl/bfw_checker.sv
sim/bilateral_filter_window_tb.sv
